// ===== hdl/prqs_pkg.sv =====
// Package for the priority ready queue scheduler: sizes, opcodes, status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package prqs_pkg;
  localparam int PRIORITY_LEVELS = 8;
  localparam int TASK_COUNT      = 64;
  localparam int EVENT_COUNT     = 16;
  localparam int MAX_RESULTS     = 64;

  localparam int TW  = 7;   // task id width
  localparam int PW  = 3;   // priority width
  localparam int EW  = 4;   // event id width
  localparam int LW  = $clog2(PRIORITY_LEVELS);
  localparam int EVW = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
  localparam int AW  = $clog2(TASK_COUNT);   // link memory address
  localparam int CW  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    OP_READY   = 3'd0,
    OP_PICK    = 3'd1,
    OP_AWAIT   = 3'd2,
    OP_REL_ONE = 3'd3,
    OP_REL_ALL = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_EV  = 2'd2,
    ST_BLOCKED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,   // check request; clear own link or read a queue head's link
    S_PUSH,     // link the task behind the queue tail
    S_POP,      // pick: drop the ready queue head
    S_REL_RD,   // release all: read the next event head's link
    S_REL_POP   // release: drop the event queue head
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;       // capture request
    logic    clr_own;    // write request task's link 0 and its level
    logic    rd_head;    // read memories at the lowest ready head
    logic    rd_rel;     // read memories at the event head
    logic    do_pick;    // pop ready queue, emit result
    logic    rel_pop;    // pop event queue head
    logic    do_push;    // append to queue tail, emit result
    logic    emit_only;  // emit a status-only result
    status_t emit_st;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t op;
    logic    tid_ok;
    logic    ev_ok;
    logic    waiting;     // request task's waiting flag
    logic    any_ready;
    logic    ev_empty;
    logic    rel_more;    // release all and more to do
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== hdl/prqs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/prqs_ctrl.sv =====
// Controller state machine for the scheduler.
// Depends on prqs_pkg.
`default_nettype none
module prqs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire prqs_pkg::dp_stat_t stat,
  output prqs_pkg::dp_cmd_t      cmd
);
  import prqs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        case (stat.op)
          OP_READY: state_nxt = (stat.tid_ok && !stat.waiting) ? S_PUSH : S_IDLE;
          OP_AWAIT:
            state_nxt = (stat.ev_ok && stat.tid_ok && !stat.waiting) ? S_PUSH : S_IDLE;
          OP_PICK:  state_nxt = stat.any_ready ? S_POP : S_IDLE;
          OP_REL_ONE, OP_REL_ALL:
            state_nxt = (stat.ev_ok && !stat.ev_empty) ? S_REL_POP : S_IDLE;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_POP:     state_nxt = S_IDLE;
      S_REL_RD:  state_nxt = S_REL_POP;
      S_REL_POP: state_nxt = S_PUSH;
      S_PUSH:    state_nxt = stat.rel_more ? S_REL_RD : S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: cmd.load = start;
      S_DECODE: begin
        case (stat.op)
          OP_READY: begin
            if (!stat.tid_ok) begin
              cmd.emit_only = 1'b1; cmd.emit_st = ST_DONE;
            end else if (stat.waiting) begin
              cmd.emit_only = 1'b1; cmd.emit_st = ST_BLOCKED;
            end else cmd.clr_own = 1'b1;
          end
          OP_PICK: begin
            if (stat.any_ready) cmd.rd_head = 1'b1;
            else begin
              cmd.emit_only = 1'b1; cmd.emit_st = ST_EMPTY;
            end
          end
          OP_AWAIT: begin
            cmd.emit_only = 1'b1;
            if (!stat.ev_ok)        cmd.emit_st = ST_BAD_EV;
            else if (!stat.tid_ok)  cmd.emit_st = ST_DONE;
            else if (stat.waiting)  cmd.emit_st = ST_BLOCKED;
            else begin
              cmd.emit_only = 1'b0; cmd.clr_own = 1'b1;
            end
          end
          OP_REL_ONE, OP_REL_ALL: begin
            if (!stat.ev_ok) begin
              cmd.emit_only = 1'b1; cmd.emit_st = ST_BAD_EV;
            end else if (stat.ev_empty) begin
              cmd.emit_only = 1'b1; cmd.emit_st = ST_EMPTY;
            end else cmd.rd_rel = 1'b1;
          end
          default: begin
            cmd.emit_only = 1'b1; cmd.emit_st = ST_DONE;
          end
        endcase
      end
      S_POP:     cmd.do_pick = 1'b1;
      S_REL_RD:  cmd.rd_rel = 1'b1;
      S_REL_POP: cmd.rel_pop = 1'b1;
      S_PUSH:    cmd.do_push = 1'b1;
      default:   cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/prqs_dp.sv =====
// Datapath: queue head/tail registers, waiting flags, link and level memories,
// result register. Depends on prqs_pkg and prqs_ram.
`default_nettype none
module prqs_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [2:0]                 in_opcode,
  input  wire logic [prqs_pkg::TW-1:0]    in_task_id,
  input  wire logic [prqs_pkg::PW-1:0]    in_priority_req,
  input  wire logic [prqs_pkg::EW-1:0]    in_event_id,
  input  wire logic [31:0]                in_wake_value,
  input  wire prqs_pkg::dp_cmd_t          cmd,
  output prqs_pkg::dp_stat_t              stat,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [prqs_pkg::TW-1:0]         out_chosen_task,
  output logic [31:0]                     out_wake_result,
  output logic                            out_last
);
  import prqs_pkg::*;

  logic [TW-1:0] ready_head_r [PRIORITY_LEVELS];
  logic [TW-1:0] ready_tail_r [PRIORITY_LEVELS];
  logic [TW-1:0] event_head_r [EVENT_COUNT];
  logic [TW-1:0] event_tail_r [EVENT_COUNT];
  logic [TASK_COUNT-1:0] waiting_r;

  opcode_t       op_r;
  logic [TW-1:0] tid_r;
  logic [LW-1:0] lvl_r;
  logic [EW-1:0] ev_r;
  logic [31:0]   wake_r;
  logic [CW-1:0] cnt_r;
  logic [LW-1:0] sel_r;     // ready level being popped
  logic [TW-1:0] cur_r;     // task being popped
  logic [LW-1:0] rel_lv_r;  // ready level of the task being released

  logic           tid_ok, ev_ok, rel_op;
  logic [AW-1:0]  tid_a, cur_a;
  logic [EVW-1:0] ev_a;

  // memories
  logic          ln_we;
  logic [AW-1:0] ln_wa, rd_a;
  logic [TW-1:0] ln_wd, ln_rd;
  logic [LW-1:0] lv_rd;

  // One write port: a push first clears its own link and then links the old
  // tail in the next cycle, the same order as the list update it stands for.
  prqs_ram #(.WIDTH(TW), .DEPTH(TASK_COUNT)) u_link (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(rd_a), .rdata(ln_rd));
  prqs_ram #(.WIDTH(LW), .DEPTH(TASK_COUNT)) u_lvl (
    .clk(clk), .we(cmd.clr_own), .waddr(tid_a), .wdata(lvl_r), .raddr(rd_a),
    .rdata(lv_rd));

  assign tid_ok = (tid_r >= TW'(1)) && (tid_r <= TW'(TASK_COUNT));
  assign ev_ok  = ({1'b0, ev_r} < (EW+1)'(EVENT_COUNT));
  assign tid_a  = AW'(tid_r - TW'(1));
  assign cur_a  = AW'(cur_r - TW'(1));
  assign ev_a   = EVW'(ev_r);
  assign rel_op = (op_r == OP_REL_ONE) || (op_r == OP_REL_ALL);

  // lowest non-empty ready level
  logic          any_ready;
  logic [LW-1:0] first_lv;
  always_comb begin
    any_ready = 1'b0;
    first_lv  = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (ready_head_r[i] != '0) begin
        any_ready = 1'b1;
        first_lv  = LW'(i);
      end
    end
  end

  // read address: the head about to be popped
  logic [TW-1:0] head_sel;
  always_comb begin
    head_sel = '0;
    if (cmd.rd_head) head_sel = ready_head_r[first_lv];
    if (cmd.rd_rel)  head_sel = event_head_r[ev_a];
  end
  assign rd_a = AW'(head_sel - TW'(1));

  // push target: event queue for await, else the ready queue of the task
  logic          push_ev;
  logic [LW-1:0] push_lv;
  logic [TW-1:0] push_t, push_tail;
  logic [TW-1:0] nx_clean;
  logic          stat_waiting;

  assign nx_clean = (ln_rd > TW'(TASK_COUNT)) ? '0 : ln_rd;
  assign stat_waiting = tid_ok ? waiting_r[tid_a] : 1'b0;

  always_comb begin
    push_ev   = (op_r == OP_AWAIT);
    push_lv   = rel_op ? rel_lv_r : lvl_r;
    push_t    = rel_op ? cur_r : tid_r;
    push_tail = push_ev ? event_tail_r[ev_a] : ready_tail_r[push_lv];
  end

  always_comb begin
    ln_we = 1'b0; ln_wa = tid_a; ln_wd = '0;
    if (cmd.clr_own) ln_we = 1'b1;
    if (cmd.do_pick || cmd.rel_pop) begin
      ln_we = 1'b1; ln_wa = cur_a;
    end
    if (cmd.do_push && push_tail != '0) begin
      ln_we = 1'b1; ln_wa = AW'(push_tail - TW'(1)); ln_wd = push_t;
    end
  end

  logic rel_more;
  assign rel_more = (op_r == OP_REL_ALL) && (event_head_r[ev_a] != '0)
                    && (cnt_r + CW'(1) < CW'(MAX_RESULTS));

  always_comb begin
    stat.op        = op_r;
    stat.tid_ok    = tid_ok;
    stat.ev_ok     = ev_ok;
    stat.waiting   = stat_waiting;
    stat.any_ready = any_ready;
    stat.ev_empty  = (event_head_r[ev_a] == '0);
    stat.rel_more  = rel_more;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        ready_head_r[i] <= '0; ready_tail_r[i] <= '0;
      end
      for (int i = 0; i < EVENT_COUNT; i++) begin
        event_head_r[i] <= '0; event_tail_r[i] <= '0;
      end
      waiting_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit_only || cmd.do_pick || cmd.do_push;
      // pick: advance the selected ready queue
      if (cmd.do_pick) begin
        ready_head_r[sel_r] <= nx_clean;
        if (nx_clean == '0) ready_tail_r[sel_r] <= '0;
      end
      // release: advance the event queue
      if (cmd.rel_pop) begin
        waiting_r[cur_a] <= 1'b0;
        event_head_r[ev_a] <= nx_clean;
        if (nx_clean == '0) event_tail_r[ev_a] <= '0;
      end
      if (cmd.do_push) begin
        if (push_ev) begin
          waiting_r[tid_a] <= 1'b1;
          if (event_tail_r[ev_a] == '0) event_head_r[ev_a] <= push_t;
          event_tail_r[ev_a] <= push_t;
        end else begin
          if (ready_tail_r[push_lv] == '0) ready_head_r[push_lv] <= push_t;
          ready_tail_r[push_lv] <= push_t;
        end
      end
    end
  end

  // result next values
  status_t       status_nxt;
  logic [TW-1:0] task_nxt;
  logic [31:0]   wake_nxt;
  logic          last_nxt;
  always_comb begin
    status_nxt = ST_DONE;
    task_nxt   = '0;
    wake_nxt   = '0;
    last_nxt   = 1'b1;
    if (cmd.emit_only) status_nxt = cmd.emit_st;
    if (cmd.do_pick) task_nxt = cur_r;
    if (cmd.do_push && rel_op) begin
      task_nxt = cur_r;
      wake_nxt = wake_r;
      last_nxt = !rel_more;
    end
  end

  // payload and request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode_t'(in_opcode);
      tid_r  <= in_task_id;
      lvl_r  <= (in_priority_req >= PW'(PRIORITY_LEVELS - 1)) ?
                LW'(PRIORITY_LEVELS - 1) : LW'(in_priority_req);
      ev_r   <= in_event_id;
      wake_r <= in_wake_value;
    end
    if (cmd.load) cnt_r <= '0;
    else if (cmd.do_push && rel_op) cnt_r <= cnt_r + CW'(1);
    if (cmd.rd_head) begin
      sel_r <= first_lv;
      cur_r <= ready_head_r[first_lv];
    end else if (cmd.rd_rel) cur_r <= event_head_r[ev_a];
    if (cmd.rel_pop) rel_lv_r <= lv_rd;
    out_status      <= status_nxt;
    out_chosen_task <= task_nxt;
    out_wake_result <= wake_nxt;
    out_last        <= last_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/priority_ready_queue_scheduler.sv =====
// Priority ready queue scheduler, top level. Depends on prqs_pkg, prqs_ctrl,
// prqs_dp (and prqs_ram through the datapath).
//
// A command is taken when start is high and busy is low. Every result shows
// on the out_ ports for one cycle with out_valid high; the receiver cannot
// stall, so each transfer completes in that cycle. A command that only gives
// a status (bad event, empty queue, blocked task, task number out of range,
// unknown opcode) keeps busy high for one cycle, in the decode state. Make
// ready and await pass through decode and push, pick through decode and pop,
// release one through decode, release pop and push, and release all repeats
// release read, release pop and push for each further task. The shared link
// memory sets these steps: one write port, so the task's own link is cleared
// before the old tail is linked to it, and a registered read, so each pop
// waits for the head's next link. The result appears the cycle after the
// last busy cycle. No clearing pass: link and level memories are read only
// for tasks that were pushed.
`default_nettype none
module priority_ready_queue_scheduler (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              in_opcode,
  input  wire logic [prqs_pkg::TW-1:0] in_task_id,
  input  wire logic [prqs_pkg::PW-1:0] in_priority_req,
  input  wire logic [prqs_pkg::EW-1:0] in_event_id,
  input  wire logic [31:0]             in_wake_value,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [prqs_pkg::TW-1:0]      out_chosen_task,
  output logic [31:0]                  out_wake_result,
  output logic                         out_last
);
  import prqs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  prqs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd));

  prqs_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_opcode(in_opcode), .in_task_id(in_task_id),
    .in_priority_req(in_priority_req), .in_event_id(in_event_id),
    .in_wake_value(in_wake_value), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_status(out_status),
    .out_chosen_task(out_chosen_task), .out_wake_result(out_wake_result),
    .out_last(out_last));
endmodule
`default_nettype wire
